FILE: hw/rtl/cle_pkg.sv
package cle_pkg;

  // Store geometry and register defaults
  localparam int unsigned LINE_STORE_DEF = 32;
  localparam int unsigned HARD_CAP       = 32;
  localparam int unsigned CAP_W          = 6;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned KIND_W         = 2;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Register indexes
  localparam int unsigned REG_LINE_CAPACITY = 0;

  // Console byte codes
  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_EOL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    SRC_RX,
    SRC_BS,
    SRC_SP,
    SRC_CR,
    SRC_LF,
    SRC_LINE,
    SRC_END
  } src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_BS1,
    ST_BS2,
    ST_BS3,
    ST_CR,
    ST_LF,
    ST_LINE,
    ST_END
  } state_e;

  typedef struct packed {
    logic latch_byte;
    logic emit;
    src_e src;
    logic last;
    logic wr_store;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_eol;
    logic bs_ok;
    logic put_ok;
    logic line_empty;
    logic line_done;
  } status_t;

endpackage

FILE: hw/rtl/cle_rx_if.sv
interface cle_rx_if import cle_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/cle_res_if.sv
interface cle_res_if import cle_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  data_byte;
  logic [COUNT_W-1:0] line_length;
  logic               last;

  modport source (output valid, output kind, output data_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input line_length,
                  input last, output ready);
endinterface

FILE: hw/rtl/cle_ram.sv
module cle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cle_ctrl.sv
module cle_ctrl import cle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (status_i.is_eol) state_d = ST_CR;
        else if (status_i.bs_ok)      state_d = ST_BS1;
        else if (status_i.put_ok)     state_d = ST_PUT;
        else                          state_d = ST_IDLE;
      end
      ST_PUT: if (status_i.out_free) state_d = ST_IDLE;
      ST_BS1: if (status_i.out_free) state_d = ST_BS2;
      ST_BS2: if (status_i.out_free) state_d = ST_BS3;
      ST_BS3: if (status_i.out_free) state_d = ST_IDLE;
      ST_CR:  if (status_i.out_free) state_d = ST_LF;
      ST_LF: begin
        if (status_i.out_free) state_d = status_i.line_empty ? ST_END : ST_LINE;
      end
      ST_LINE: begin
        if (status_i.out_free && status_i.line_done) state_d = ST_END;
      end
      ST_END: if (status_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.src  = SRC_RX;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.latch_byte = in_valid_i;
      end
      ST_DECODE: ;
      ST_PUT: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.src      = SRC_RX;
        cmd_o.last     = 1'b1;
        cmd_o.wr_store = status_i.out_free;
        cmd_o.cnt_inc  = status_i.out_free;
      end
      ST_BS1: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.src     = SRC_BS;
        cmd_o.cnt_dec = status_i.out_free;
      end
      ST_BS2: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.src  = SRC_SP;
      end
      ST_BS3: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.src  = SRC_BS;
        cmd_o.last = 1'b1;
      end
      ST_CR: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.src  = SRC_CR;
      end
      ST_LF: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.src     = SRC_LF;
        cmd_o.idx_clr = 1'b1;
      end
      ST_LINE: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.src     = SRC_LINE;
        cmd_o.idx_inc = status_i.out_free;
      end
      ST_END: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.src     = SRC_END;
        cmd_o.last    = 1'b1;
        cmd_o.cnt_clr = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/cle_datapath.sv
module cle_datapath import cle_pkg::*; #(
  parameter int unsigned LineStore = LINE_STORE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cap_we_i,
  input  logic [CAP_W-1:0]    cap_wdata_i,
  output logic [CAP_W-1:0]    cap_o,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  cle_res_if.source           res
);

  localparam int unsigned AddrW  = $clog2(LineStore);
  localparam int unsigned CapLim = (LineStore < HARD_CAP) ? LineStore : HARD_CAP;
  localparam logic [CAP_W:0] CapLimV = (CAP_W+1)'(CapLim);

  logic [CAP_W-1:0]   cap_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] idx_q, idx_d;

  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [BYTE_W-1:0]  data_q, data_d;
  logic [COUNT_W-1:0] len_q, len_d;
  logic               last_q, last_d;

  logic [CAP_W:0]       eff_cap;
  logic [CAP_W:0]       count_p1;
  logic [COUNT_W:0]     idx_p1;
  logic [AddrW+COUNT_W-1:0] waddr_ext, raddr_ext;
  logic [CHAR_W-1:0]    rdata;
  logic                 is_print;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cap_we_i) cap_q <= cap_wdata_i;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_byte) byte_q <= rx_byte_i;
    kind_q <= kind_d;
    data_q <= data_d;
    len_q  <= len_d;
    last_q <= last_d;
  end

  assign cap_o    = cap_q;
  assign eff_cap  = ({1'b0, cap_q} > CapLimV) ? CapLimV : {1'b0, cap_q};
  assign count_p1 = (CAP_W+1)'(count_q) + (CAP_W+1)'(1);
  assign idx_p1   = {1'b0, idx_q} + (COUNT_W+1)'(1);
  assign is_print = (byte_q >= CH_SP) && (byte_q < CH_DEL);

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.cnt_clr) count_d = '0;
    else if (cmd_i.cnt_inc)     count_d = count_q + COUNT_W'(1);
    else if (cmd_i.cnt_dec)     count_d = count_q - COUNT_W'(1);
    else                        count_d = count_q;
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_clr) idx_d = '0;
    else if (cmd_i.idx_inc)     idx_d = idx_p1[COUNT_W-1:0];
    else                        idx_d = idx_q;
  end

  // Read address follows the next index so the data lines up with idx_q
  assign waddr_ext = (AddrW+COUNT_W)'(count_q);
  assign raddr_ext = (AddrW+COUNT_W)'(idx_d);

  cle_ram #(
    .Width (CHAR_W),
    .Depth (LineStore)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_store),
    .waddr_i (waddr_ext[AddrW-1:0]),
    .wdata_i (byte_q[CHAR_W-1:0]),
    .raddr_i (raddr_ext[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !res.ready;
    kind_d      = kind_q;
    data_d      = data_q;
    len_d       = len_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_ECHO;
      len_d       = '0;
      last_d      = cmd_i.last;
      unique case (cmd_i.src)
        SRC_RX:   data_d = byte_q;
        SRC_BS:   data_d = CH_BS;
        SRC_SP:   data_d = CH_SP;
        SRC_CR:   data_d = CH_CR;
        SRC_LF:   data_d = CH_LF;
        SRC_LINE: begin
          kind_d = KIND_LINE;
          data_d = {1'b0, rdata};
        end
        SRC_END: begin
          kind_d = KIND_EOL;
          data_d = '0;
          len_d  = count_q;
        end
        default:  data_d = '0;
      endcase
    end
  end

  assign res.valid       = out_valid_q;
  assign res.kind        = kind_q;
  assign res.data_byte   = data_q;
  assign res.line_length = len_q;
  assign res.last        = last_q;

  assign status_o.out_free   = !out_valid_q || res.ready;
  assign status_o.is_eol     = (byte_q == CH_CR) || (byte_q == CH_LF);
  assign status_o.bs_ok      = ((byte_q == CH_BS) || (byte_q == CH_DEL)) && (count_q != '0);
  assign status_o.put_ok     = is_print && (count_p1 < eff_cap);
  assign status_o.line_empty = (count_q == '0);
  assign status_o.line_done  = (idx_p1 == {1'b0, count_q});

endmodule

FILE: hw/rtl/console_line_editor.sv
// Console line editor: one received byte in, echo/line/end-of-line items out.
// An accepted byte is decoded (ST_DECODE), then its first item is emitted into the output register.
// Bytes are handled sequentially, one at a time: the input is not ready again until the sequencer
// has emitted every item for the current byte, and a stalled sink holds the sequence.
// The line end streams one item per cycle out of the line store (registered read port) while the sink is ready.
// Reset (rst_ni low, asynchronous) empties the line, sets line_capacity to 32, drops outputs.
module console_line_editor import cle_pkg::*; #(
  parameter int unsigned LineStore = LINE_STORE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cle_rx_if.sink             in_i,
  cle_res_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cmd_t             cmd;
  status_t          status;
  logic             cap_we;
  logic             cap_sel;
  logic [CAP_W-1:0] cap;

  // APB: zero wait states; one register word, selected by the word index of paddr
  assign pready  = 1'b1;
  assign cap_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_LINE_CAPACITY));
  assign cap_we  = psel && penable && pwrite && cap_sel;
  assign prdata  = cap_sel ? PDATA_W'(cap) : '0;

  // Sequencer: walks echo, line playback and end marker, one item per cycle while the output is free
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: byte register, char count, line store, output register
  cle_datapath #(
    .LineStore (LineStore)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_we_i    (cap_we),
    .cap_wdata_i (pwdata[CAP_W-1:0]),
    .cap_o       (cap),
    .rx_byte_i   (in_i.rx_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .res         (out_o)
  );

endmodule
